[rtl/core/pulse_position_code_receiver_core_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the pulse-position code receiver
// Shared wrappers so every concurrent check uses the same clock, reset and
// reporting form.
// ----------------------------------------------------------------------------
`ifndef PULSE_POSITION_CODE_RECEIVER_CORE_MACROS_SVH
`define PULSE_POSITION_CODE_RECEIVER_CORE_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define PPCR_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define PPCR_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/core/ppcr_pkg.sv]
// ----------------------------------------------------------------------------
// ppcr_pkg
// Sizes, codes and shared types of the pulse-position code receiver.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package ppcr_pkg;

    localparam int CODE_SLOTS = 1024;
    localparam int CODE_BITS  = 24;

    // Store address and fill count widths.
    localparam int SLOT_AW = (CODE_SLOTS > 1) ? $clog2(CODE_SLOTS) : 1;
    localparam int COUNT_W = $clog2(CODE_SLOTS + 1);
    // Bit position inside a frame, 0 .. CODE_BITS-1.
    localparam int BI_W    = $clog2(CODE_BITS);

    localparam logic [CODE_BITS-1:0] CODE_SHIFT_RESET = CODE_BITS'(32'hF11111);

    localparam logic [7:0] SYNC_TIME = 8'd20;
    localparam logic [7:0] ZERO_TIME = 8'd8;
    localparam logic [7:0] ONE_TIME  = 8'd20;

    // Input function selector.
    localparam logic [1:0] FUNC_PULSE = 2'd0;
    localparam logic [1:0] FUNC_ACK   = 2'd1;
    localparam logic [1:0] FUNC_CLEAR = 2'd2;

    // Configuration register indexes and reset values.
    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_WIDTH = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ZERO_LOW  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ZERO_HIGH = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_ONE_LOW   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_ONE_HIGH  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT   = 3'd5;

    localparam logic [7:0] RST_MIN_WIDTH = 8'd14;
    localparam logic [7:0] RST_ZERO_LOW  = 8'd27;
    localparam logic [7:0] RST_ZERO_HIGH = 8'd35;
    localparam logic [7:0] RST_ONE_LOW   = 8'd40;
    localparam logic [7:0] RST_ONE_HIGH  = 8'd47;
    localparam logic [7:0] RST_TIMEOUT   = 8'd48;

    typedef enum logic [1:0] {
        STATUS_KNOWN = 2'd0,
        STATUS_NEW   = 2'd1,
        STATUS_FULL  = 2'd2
    } t_status;

    typedef struct packed {
        logic                 start;
        logic                 clear;
        logic [CODE_BITS-1:0] code;
    } t_store_req;

    typedef struct packed {
        logic    done;
        t_status status;
    } t_store_rsp;

endpackage

`default_nettype wire

[rtl/core/pulse_position_code_receiver_core.sv]
// ----------------------------------------------------------------------------
// pulse_position_code_receiver_core
// Decodes pulse-position remote codes and learns them in an on-chip store.
// ----------------------------------------------------------------------------
// Usage:
// The input channel (i_in_valid / o_in_ready) carries one word per pulse
// falling edge or command: i_func selects pulse, acknowledge or clear-store.
// Every accepted word yields exactly one result word on the output channel
// (o_out_valid / i_out_ready), in order.
// Lookup: a word that completes a code scans the code store one entry per
// cycle through the RAM's single registered read port, until it finds the
// code or has passed every stored code; other words skip the scan.
// Flow: one word at a time; the next word is accepted as soon as the
// previous result has moved into the output register.
// Reset (synchronous, active low) restores the configuration defaults,
// clears the decoder, empties the store and drops the new-code mark.
// When the consumer stalls, the finished result waits in an internal
// holding state and the input side stops accepting until the output
// register frees up. Configuration is written through i_cfg_we /
// i_cfg_index / i_cfg_data between words; indexes past the six registers
// are ignored.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "pulse_position_code_receiver_core_macros.svh"

module pulse_position_code_receiver_core
    import ppcr_pkg::*;
(
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,

    input  wire logic                 i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [7:0]           i_cfg_data,

    input  wire logic                 i_in_valid,
    output logic                      o_in_ready,
    input  wire logic [1:0]           i_func,
    input  wire logic [7:0]           i_pulse_width,
    input  wire logic [7:0]           i_gap_ticks,

    output logic                      o_out_valid,
    input  wire logic                 i_out_ready,
    output logic                      o_code_ready,
    output logic [CODE_BITS-1:0]      o_code_value,
    output logic [1:0]                o_store_status,
    output logic                      o_new_mark,
    output logic [COUNT_W-1:0]        o_stored_count
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_LOOKUP,
        ST_RESULT
    } t_state;

    // Configuration registers.
    logic [7:0] r_min_width;
    logic [7:0] r_zero_low;
    logic [7:0] r_zero_high;
    logic [7:0] r_one_low;
    logic [7:0] r_one_high;
    logic [7:0] r_timeout;

    // Decoder state.
    logic [BI_W-1:0]      r_bit_index;
    logic [7:0]           r_frame_time;
    logic [CODE_BITS-1:0] r_code_shift;
    logic                 r_new_flag;
    t_state               r_state;

    // Result waiting for the output register.
    logic                 r_pend_ready;
    logic [CODE_BITS-1:0] r_pend_value;
    t_status              r_pend_status;

    // Output register.
    logic                 r_out_valid;
    logic                 r_out_code_ready;
    logic [CODE_BITS-1:0] r_out_code_value;
    logic [1:0]           r_out_status;
    logic                 r_out_new_mark;
    logic [COUNT_W-1:0]   r_out_count;

    // Next-state values of the decoder for the word at the input.
    logic [BI_W-1:0]      n_bit_index;
    logic [7:0]           n_frame_time;
    logic [CODE_BITS-1:0] n_code_shift;

    logic                 w_accept;
    logic                 w_pulse;
    logic                 w_complete;
    logic                 w_code_done;
    logic                 w_out_free;
    logic                 w_out_load;
    logic [7:0]           w_gap;
    logic [7:0]           w_time;
    logic                 w_in_zero;
    logic                 w_in_one;
    logic [BI_W:0]        w_bit_inc;
    logic [BI_W-1:0]      w_bit_pos;

    t_store_req           w_req;
    t_store_rsp           w_rsp;
    logic [COUNT_W-1:0]   w_fill;

    assign w_accept   = i_in_valid && o_in_ready;
    assign w_out_free = !r_out_valid || i_out_ready;
    assign w_out_load = (r_state == ST_RESULT) && w_out_free;
    assign w_pulse    = (i_func == FUNC_PULSE) && (i_pulse_width >= r_min_width);

    // Frame time after adding this pulse's gap; long gaps count as nothing.
    assign w_gap     = (i_gap_ticks >= r_timeout) ? 8'd0 : i_gap_ticks;
    assign w_time    = r_frame_time + w_gap;
    assign w_in_zero = (w_time >= r_zero_low) && (w_time <= r_zero_high);
    assign w_in_one  = (w_time >= r_one_low) && (w_time <= r_one_high);
    assign w_bit_inc = {1'b0, r_bit_index} + (BI_W+1)'(1);
    // The first bit of a frame lands in the most significant position.
    assign w_bit_pos = BI_W'(CODE_BITS - 1) - r_bit_index;

    always_comb begin
        n_bit_index  = r_bit_index;
        n_frame_time = r_frame_time;
        n_code_shift = r_code_shift;
        w_complete   = 1'b0;
        if ((r_bit_index != '0) && (w_in_zero || w_in_one)) begin
            n_frame_time            = w_in_zero ? ZERO_TIME : ONE_TIME;
            n_code_shift[w_bit_pos] = !w_in_zero;
            if (w_bit_inc == (BI_W+1)'(CODE_BITS)) begin
                n_bit_index = '0;
                w_complete  = 1'b1;
            end else begin
                n_bit_index = w_bit_inc[BI_W-1:0];
            end
        end else begin
            // Sync pulse, either at frame start or after a framing error.
            n_frame_time                = SYNC_TIME;
            n_code_shift[CODE_BITS-1]   = 1'b1;
            n_bit_index                 = BI_W'(1);
        end
    end

    // An accepted pulse that delivers the last bit of a code.
    assign w_code_done = w_pulse && w_complete;

    assign w_req.start = w_accept && w_code_done;
    assign w_req.clear = w_accept && (i_func == FUNC_CLEAR);
    assign w_req.code  = n_code_shift;

    ppcr_store u_store (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_req),
        .o_rsp   (w_rsp),
        .o_fill  (w_fill)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_width <= RST_MIN_WIDTH;
            r_zero_low  <= RST_ZERO_LOW;
            r_zero_high <= RST_ZERO_HIGH;
            r_one_low   <= RST_ONE_LOW;
            r_one_high  <= RST_ONE_HIGH;
            r_timeout   <= RST_TIMEOUT;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_MIN_WIDTH: r_min_width <= i_cfg_data;
                CFG_ZERO_LOW:  r_zero_low  <= i_cfg_data;
                CFG_ZERO_HIGH: r_zero_high <= i_cfg_data;
                CFG_ONE_LOW:   r_one_low   <= i_cfg_data;
                CFG_ONE_HIGH:  r_one_high  <= i_cfg_data;
                CFG_TIMEOUT:   r_timeout   <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    // Control sequencer with the decoder state and the output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_bit_index  <= '0;
            r_frame_time <= '0;
            r_code_shift <= CODE_SHIFT_RESET;
            r_new_flag   <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            // A new result takes the output register as soon as it is free.
            if (w_out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                ST_IDLE: begin
                    if (w_accept) begin
                        r_pend_ready  <= w_code_done;
                        r_pend_value  <= w_code_done ? n_code_shift : '0;
                        r_pend_status <= STATUS_KNOWN;
                        if (w_code_done) begin
                            r_state <= ST_LOOKUP;
                        end else begin
                            r_state <= ST_RESULT;
                        end
                        if (i_func == FUNC_ACK) begin
                            r_new_flag <= 1'b0;
                        end
                        if (w_pulse) begin
                            r_bit_index  <= n_bit_index;
                            r_frame_time <= n_frame_time;
                            r_code_shift <= n_code_shift;
                        end
                    end
                end
                ST_LOOKUP: begin
                    if (w_rsp.done) begin
                        r_pend_status <= w_rsp.status;
                        if (w_rsp.status == STATUS_NEW) begin
                            r_new_flag <= 1'b1;
                        end
                        r_state <= ST_RESULT;
                    end
                end
                ST_RESULT: begin
                    if (w_out_free) begin
                        r_out_code_ready <= r_pend_ready;
                        r_out_code_value <= r_pend_value;
                        r_out_status     <= r_pend_status;
                        r_out_new_mark   <= r_new_flag;
                        r_out_count      <= w_fill;
                        r_state          <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    assign o_in_ready     = (r_state == ST_IDLE);
    assign o_out_valid    = r_out_valid;
    assign o_code_ready   = r_out_code_ready;
    assign o_code_value   = r_out_code_value;
    assign o_store_status = r_out_status;
    assign o_new_mark     = r_out_new_mark;
    assign o_stored_count = r_out_count;

    // A store answer only ever arrives while a lookup is outstanding.
    `PPCR_ASSERT_NOW(a_rsp_in_lookup, i_clk, i_rst_n, w_rsp.done, r_state == ST_LOOKUP, "store answer outside lookup")
    // A completed code always starts a lookup in the next cycle.
    `PPCR_ASSERT_NEXT(a_start_lookup, i_clk, i_rst_n, w_req.start, r_state == ST_LOOKUP, "lookup not started")
    // Freshly stored codes raise the new mark in the same result.
    `PPCR_ASSERT_NOW(a_new_sets_mark, i_clk, i_rst_n, o_out_valid && o_code_ready && (o_store_status == STATUS_NEW), o_new_mark, "new code without new mark")
    // The fill count never passes the store size.
    `PPCR_ASSERT_NOW(a_fill_bound, i_clk, i_rst_n, 1'b1, w_fill <= COUNT_W'(CODE_SLOTS), "fill count overflow")

endmodule

`default_nettype wire

[rtl/core/ppcr_store.sv]
// ----------------------------------------------------------------------------
// ppcr_store
// Learned-code store: a single-port RAM scanned one entry per cycle, with
// append on a miss if room is left, and a fill count, not per-entry valid bits.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ppcr_store
    import ppcr_pkg::*;
(
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire t_store_req         i_req,
    output t_store_rsp              o_rsp,
    output logic [COUNT_W-1:0]      o_fill
);

    typedef enum logic {
        SS_IDLE,
        SS_SCAN
    } t_sstate;

    logic [CODE_BITS-1:0] r_mem [CODE_SLOTS];
    logic [CODE_BITS-1:0] r_rdata;
    logic [CODE_BITS-1:0] r_code;
    logic [COUNT_W-1:0]   r_addr;
    logic [COUNT_W-1:0]   r_fill;
    logic                 r_cmp_valid;
    t_sstate              r_state;
    t_store_rsp           r_rsp;

    logic w_hit;
    logic w_miss;
    logic w_has_room;
    logic w_we;

    // A compare is pending whenever a read was issued in the previous cycle.
    assign w_hit      = (r_state == SS_SCAN) && r_cmp_valid && (r_rdata == r_code);
    assign w_miss     = (r_state == SS_SCAN) && (r_addr == r_fill) && !w_hit;
    assign w_has_room = (r_fill < COUNT_W'(CODE_SLOTS));
    assign w_we       = w_miss && w_has_room;

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[r_fill[SLOT_AW-1:0]] <= r_code;
        end
        r_rdata <= r_mem[r_addr[SLOT_AW-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= SS_IDLE;
            r_fill      <= '0;
            r_addr      <= '0;
            r_cmp_valid <= 1'b0;
            r_rsp       <= '0;
        end else begin
            r_rsp.done <= w_hit || w_miss;
            case (r_state)
                SS_IDLE: begin
                    r_cmp_valid <= 1'b0;
                    r_addr      <= '0;
                    if (i_req.clear) begin
                        r_fill <= '0;
                    end
                    if (i_req.start) begin
                        r_state <= SS_SCAN;
                    end
                end
                SS_SCAN: begin
                    if (w_hit) begin
                        r_rsp.status <= STATUS_KNOWN;
                        r_state      <= SS_IDLE;
                    end else if (w_miss) begin
                        r_rsp.status <= w_has_room ? STATUS_NEW : STATUS_FULL;
                        if (w_has_room) begin
                            r_fill <= r_fill + COUNT_W'(1);
                        end
                        r_state <= SS_IDLE;
                    end else begin
                        r_addr      <= r_addr + COUNT_W'(1);
                        r_cmp_valid <= 1'b1;
                    end
                end
                default: begin
                    r_state <= SS_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if ((r_state == SS_IDLE) && i_req.start) begin
            r_code <= i_req.code;
        end
    end

    assign o_rsp  = r_rsp;
    assign o_fill = r_fill;

endmodule

`default_nettype wire

[tb/sv/testbench.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Testbench for pulse_position_code_receiver_core
// Feeds pulse edges and commands through the input handshake. A cycle-free
// decoder model predicts every result word. The monitor checks each result
// word field by field; both sides stall at random in phases one and two.
// ----------------------------------------------------------------------------

module testbench;

    import ppcr_pkg::*;

    // The selector value that the block must treat as a no-op.
    localparam logic [1:0] FUNC_UNUSED = 2'd3;

    // Stride and offset that give distinct 23-bit payloads for the store fill.
    localparam int unsigned FILL_STRIDE = 32'h002C_1B3D;
    localparam int unsigned FILL_OFFSET = 32'h0015_5555;

    // Even if every one of the roughly 600 words completed a code against a
    // full store, the run would end well inside the limit, with a wide margin.
    localparam int unsigned RUN_LIMIT_NS = 40_000_000;
    // Long enough for a code completion that scans a full store.
    localparam int unsigned SETTLE_CYCLES = 1100;

    typedef struct packed {
        logic [1:0] func;
        logic [7:0] width;
        logic [7:0] gap;
    } t_rx_word;

    typedef struct packed {
        logic                 code_ready;
        logic [CODE_BITS-1:0] code_value;
        t_status              status;
        logic                 new_mark;
        logic [COUNT_W-1:0]   stored_count;
    } t_rx_result;

    // ------------------------------------------------------------------
    // Signals to and from the block. Every input starts at a known value.
    // ------------------------------------------------------------------
    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [7:0]           cfg_data = '0;
    logic                 in_valid = 1'b0;
    logic                 in_ready;
    logic [1:0]           in_func = FUNC_PULSE;
    logic [7:0]           in_width = '0;
    logic [7:0]           in_gap = '0;
    logic                 out_valid;
    logic                 out_ready = 1'b0;
    logic                 out_code_ready;
    logic [CODE_BITS-1:0] out_code_value;
    logic [1:0]           out_status;
    logic                 out_new_mark;
    logic [COUNT_W-1:0]   out_count;

    pulse_position_code_receiver_core uut (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_cfg_we       (cfg_we),
        .i_cfg_index    (cfg_index),
        .i_cfg_data     (cfg_data),
        .i_in_valid     (in_valid),
        .o_in_ready     (in_ready),
        .i_func         (in_func),
        .i_pulse_width  (in_width),
        .i_gap_ticks    (in_gap),
        .o_out_valid    (out_valid),
        .i_out_ready    (out_ready),
        .o_code_ready   (out_code_ready),
        .o_code_value   (out_code_value),
        .o_store_status (out_status),
        .o_new_mark     (out_new_mark),
        .o_stored_count (out_count)
    );

    // ------------------------------------------------------------------
    // Decoder model: its own copy of the registers, the frame decoder and
    // the learned-code store.
    // ------------------------------------------------------------------
    logic [7:0]           rx_cfg [0:5];
    int unsigned          dec_bit_pos;
    logic [7:0]           dec_frame_time;
    logic [CODE_BITS-1:0] dec_shift;
    logic [CODE_BITS-1:0] learned_codes [CODE_SLOTS];
    int unsigned          learned_count;
    logic                 learned_flag;

    // Stimulus and scoreboard state.
    t_rx_word             pending_words [$];
    t_rx_result           expected_decodes [$];
    t_rx_word             held_word;
    t_rx_result           seen_result;
    logic [CODE_BITS-2:0] code_pool [8];
    int unsigned          send_idle_pct = 0;
    int unsigned          recv_idle_pct = 0;
    int unsigned          words_queued = 0;
    int unsigned          words_accepted = 0;
    int unsigned          mismatches = 0;
    int unsigned          known_codes = 0;
    int unsigned          learned_codes_seen = 0;
    int unsigned          refused_codes = 0;

    // Looks a finished code up in the store and appends it when it is new
    // and a slot is free. A full store leaves the new mark as it is.
    function automatic t_status learn_code(input logic [CODE_BITS-1:0] code);
        int unsigned k;
        for (k = 0; k < learned_count; k++) begin
            if (learned_codes[k] == code) begin
                return STATUS_KNOWN;
            end
        end
        if (learned_count < CODE_SLOTS) begin
            learned_codes[learned_count] = code;
            learned_count++;
            learned_flag = 1'b1;
            return STATUS_NEW;
        end
        return STATUS_FULL;
    endfunction

    // Advances the model by one accepted word and returns the result word
    // that the block must produce for it.
    function automatic t_rx_result decode_word(input t_rx_word w);
        t_rx_result r;
        logic       sync;
        logic [7:0] step;
        r = '0;
        r.status = STATUS_KNOWN;
        if (w.func == FUNC_ACK) begin
            learned_flag = 1'b0;
        end else if (w.func == FUNC_CLEAR) begin
            learned_count = 0;
        end else if (w.func == FUNC_PULSE && w.width >= rx_cfg[CFG_MIN_WIDTH]) begin
            sync = (dec_bit_pos == 0);
            if (!sync) begin
                // A gap at or past the timeout adds nothing; the sum wraps at 8 bits.
                step = (w.gap >= rx_cfg[CFG_TIMEOUT]) ? 8'd0 : w.gap;
                dec_frame_time = dec_frame_time + step;
                if (dec_frame_time >= rx_cfg[CFG_ZERO_LOW]
                        && dec_frame_time <= rx_cfg[CFG_ZERO_HIGH]) begin
                    dec_frame_time = ZERO_TIME;
                    dec_shift[CODE_BITS - 1 - dec_bit_pos] = 1'b0;
                    dec_bit_pos++;
                end else if (dec_frame_time >= rx_cfg[CFG_ONE_LOW]
                        && dec_frame_time <= rx_cfg[CFG_ONE_HIGH]) begin
                    dec_frame_time = ONE_TIME;
                    dec_shift[CODE_BITS - 1 - dec_bit_pos] = 1'b1;
                    dec_bit_pos++;
                end else begin
                    // Outside both windows: the frame aborts and this pulse
                    // becomes the sync of a fresh one.
                    dec_bit_pos = 0;
                    sync = 1'b1;
                end
                if (!sync && dec_bit_pos >= CODE_BITS) begin
                    dec_bit_pos = 0;
                    r.code_ready = 1'b1;
                    r.code_value = dec_shift;
                    r.status = learn_code(dec_shift);
                end
            end
            if (sync) begin
                dec_frame_time = SYNC_TIME;
                dec_shift[CODE_BITS - 1] = 1'b1;
                dec_bit_pos = 1;
            end
        end
        r.new_mark = learned_flag;
        r.stored_count = COUNT_W'(learned_count);
        return r;
    endfunction

    function automatic void compare_decode(input t_rx_result want, input t_rx_result got);
        if (want.code_ready !== got.code_ready || want.code_value !== got.code_value
                || want.status !== got.status || want.new_mark !== got.new_mark
                || want.stored_count !== got.stored_count) begin
            mismatches++;
            if (mismatches <= 10) begin
                $display("ERROR @%0t: expected ready=%0d code=%h status=%0d mark=%0d count=%0d",
                         $realtime, want.code_ready, want.code_value, want.status,
                         want.new_mark, want.stored_count);
                $display("               got ready=%0d code=%h status=%0d mark=%0d count=%0d",
                         got.code_ready, got.code_value, got.status,
                         got.new_mark, got.stored_count);
            end
        end
    endfunction

    // ------------------------------------------------------------------
    // Clock and run limit.
    // ------------------------------------------------------------------
    initial begin
        forever #5 clk = ~clk;
    end

    initial begin
        #(RUN_LIMIT_NS);
        $display("Timeout: %0d words accepted, %0d results still expected.",
                 words_accepted, expected_decodes.size());
        $display("DONE: errors detected");
        $finish;
    end

    // ------------------------------------------------------------------
    // Driver: takes the next word from the pending queue whenever the
    // input register is free, unless it idles this cycle. The expected
    // result is worked out at the edge that accepts the word.
    // ------------------------------------------------------------------
    always @(posedge clk) begin
        if (!rst_n) begin
            in_valid <= 1'b0;
        end else begin
            if (in_valid && in_ready) begin
                expected_decodes.push_back(decode_word(held_word));
                words_accepted++;
            end
            if (!in_valid || in_ready) begin
                if (pending_words.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
                    held_word = pending_words.pop_front();
                    in_valid <= 1'b1;
                    in_func <= held_word.func;
                    in_width <= held_word.width;
                    in_gap <= held_word.gap;
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Monitor: every accepted result word is compared with the oldest
    // expectation. Only the first ten mismatches are printed in full.
    // ------------------------------------------------------------------
    always @(posedge clk) begin
        if (!rst_n) begin
            out_ready <= 1'b0;
        end else begin
            if (out_valid && out_ready) begin
                seen_result.code_ready = out_code_ready;
                seen_result.code_value = out_code_value;
                seen_result.status = t_status'(out_status);
                seen_result.new_mark = out_new_mark;
                seen_result.stored_count = out_count;
                if (expected_decodes.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10) begin
                        $display("ERROR @%0t: result word with nothing expected", $realtime);
                    end
                end else begin
                    compare_decode(expected_decodes.pop_front(), seen_result);
                end
                if (seen_result.code_ready) begin
                    if (seen_result.status == STATUS_KNOWN) begin
                        known_codes++;
                    end else if (seen_result.status == STATUS_NEW) begin
                        learned_codes_seen++;
                    end else begin
                        refused_codes++;
                    end
                end
            end
            out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers.
    // ------------------------------------------------------------------
    task automatic queue_word(input logic [1:0] f, input logic [7:0] w, input logic [7:0] g);
        t_rx_word item;
        item.func = f;
        item.width = w;
        item.gap = g;
        pending_words.push_back(item);
        words_queued++;
    endtask

    function automatic logic [7:0] accepted_width();
        return 8'($urandom_range(rx_cfg[CFG_MIN_WIDTH], 255));
    endfunction

    // Searches, from a random start, for a gap that moves the frame time
    // into the window of the wanted bit. Returns -1 when no gap can.
    function automatic int pick_gap(input logic [7:0] ft, input logic want_one);
        int         start;
        int         g;
        int         k;
        logic [7:0] t;
        logic       zero_hit;
        logic       one_hit;
        start = $urandom_range(0, 255);
        for (k = 0; k < 256; k++) begin
            g = (start + k) % 256;
            t = ft + ((g >= rx_cfg[CFG_TIMEOUT]) ? 8'd0 : 8'(g));
            zero_hit = (t >= rx_cfg[CFG_ZERO_LOW]) && (t <= rx_cfg[CFG_ZERO_HIGH]);
            one_hit = !zero_hit && (t >= rx_cfg[CFG_ONE_LOW]) && (t <= rx_cfg[CFG_ONE_HIGH]);
            if (want_one ? one_hit : zero_hit) begin
                return g;
            end
        end
        return -1;
    endfunction

    // Queues one frame: a sync pulse and 23 data pulses carrying the payload,
    // with the odd too-short pulse mixed in. A damaged frame stops with a
    // pulse at a random gap.
    task automatic queue_frame(input logic [CODE_BITS-2:0] payload, input bit may_break);
        logic [7:0] ft;
        int         gap;
        int         cut;
        int         k;
        logic       bit_val;
        cut = CODE_BITS;
        if (may_break && $urandom_range(0, 99) < 15) begin
            cut = $urandom_range(1, CODE_BITS - 1);
        end
        // The sync gap is at or past the timeout, so it adds nothing. With
        // windows that hold neither 8 nor 20 this pulse aborts any half-done
        // frame and restarts the decoder, wherever it stood.
        queue_word(FUNC_PULSE, accepted_width(),
                   8'($urandom_range(rx_cfg[CFG_TIMEOUT], 255)));
        ft = SYNC_TIME;
        for (k = 1; k < CODE_BITS; k++) begin
            if (rx_cfg[CFG_MIN_WIDTH] != 0 && $urandom_range(0, 9) == 0) begin
                queue_word(FUNC_PULSE, 8'($urandom_range(0, rx_cfg[CFG_MIN_WIDTH] - 1)),
                           8'($urandom()));
            end
            bit_val = payload[CODE_BITS - 1 - k];
            gap = (k == cut) ? -1 : pick_gap(ft, bit_val);
            if (gap < 0) begin
                queue_word(FUNC_PULSE, accepted_width(), 8'($urandom()));
                return;
            end
            queue_word(FUNC_PULSE, accepted_width(), 8'(gap));
            ft = bit_val ? ONE_TIME : ZERO_TIME;
        end
    endtask

    // Mostly whole frames, some with known payloads, plus commands and noise.
    task automatic queue_mixed(input int unsigned n_words);
        int unsigned          target;
        int unsigned          pick;
        logic [CODE_BITS-2:0] payload;
        target = words_queued + n_words;
        while (words_queued < target) begin
            pick = $urandom_range(0, 99);
            if (pick < 72) begin
                if ($urandom_range(0, 99) < 40) begin
                    payload = code_pool[$urandom_range(0, 7)];
                end else begin
                    payload = (CODE_BITS - 1)'($urandom());
                end
                queue_frame(payload, 1'b1);
            end else if (pick < 82) begin
                queue_word(FUNC_ACK, 8'($urandom()), 8'($urandom()));
            end else if (pick < 86) begin
                queue_word(FUNC_CLEAR, 8'($urandom()), 8'($urandom()));
            end else if (pick < 89) begin
                queue_word(FUNC_UNUSED, 8'($urandom()), 8'($urandom()));
            end else begin
                queue_word(2'($urandom_range(0, 3)), 8'($urandom()), 8'($urandom()));
            end
        end
    endtask

    // Unstructured words for settings under which frames cannot be built.
    task automatic queue_noise(input int unsigned n_words, input int unsigned pulse_pct,
                               input int unsigned wide_pct);
        int unsigned k;
        logic [1:0]  f;
        logic [7:0]  w;
        for (k = 0; k < n_words; k++) begin
            f = ($urandom_range(0, 99) < pulse_pct) ? FUNC_PULSE : 2'($urandom_range(1, 3));
            w = ($urandom_range(0, 99) < wide_pct) ? 8'd255 : 8'($urandom());
            queue_word(f, w, 8'($urandom()));
        end
    endtask

    function automatic logic [CODE_BITS-2:0] fill_payload(input int unsigned n);
        return (CODE_BITS - 1)'(n * FILL_STRIDE + FILL_OFFSET);
    endfunction

    // Holds the sender until every queued word has been taken and every
    // expected result has come back.
    task automatic wait_drained();
        while (pending_words.size() != 0 || in_valid || expected_decodes.size() != 0) begin
            @(negedge clk);
        end
    endtask

    task automatic put_reg(input logic [CFG_IDX_W-1:0] idx, input logic [7:0] val);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        rx_cfg[idx] = val;
    endtask

    // Writes all six registers on back-to-back edges while the block is idle.
    task automatic load_settings(input logic [7:0] min_w, input logic [7:0] z_lo,
                                 input logic [7:0] z_hi, input logic [7:0] o_lo,
                                 input logic [7:0] o_hi, input logic [7:0] tmo);
        put_reg(CFG_MIN_WIDTH, min_w);
        put_reg(CFG_ZERO_LOW, z_lo);
        put_reg(CFG_ZERO_HIGH, z_hi);
        put_reg(CFG_ONE_LOW, o_lo);
        put_reg(CFG_ONE_HIGH, o_hi);
        put_reg(CFG_TIMEOUT, tmo);
        @(posedge clk);
        cfg_we <= 1'b0;
        @(negedge clk);
    endtask

    task automatic set_idling(input int unsigned send_pct, input int unsigned recv_pct);
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
    endtask

    // ------------------------------------------------------------------
    // Test sequence.
    // ------------------------------------------------------------------
    initial begin
        int unsigned k;

        // The model starts from the reset state of the block.
        rx_cfg[CFG_MIN_WIDTH] = RST_MIN_WIDTH;
        rx_cfg[CFG_ZERO_LOW] = RST_ZERO_LOW;
        rx_cfg[CFG_ZERO_HIGH] = RST_ZERO_HIGH;
        rx_cfg[CFG_ONE_LOW] = RST_ONE_LOW;
        rx_cfg[CFG_ONE_HIGH] = RST_ONE_HIGH;
        rx_cfg[CFG_TIMEOUT] = RST_TIMEOUT;
        dec_bit_pos = 0;
        dec_frame_time = '0;
        dec_shift = CODE_SHIFT_RESET;
        learned_count = 0;
        learned_flag = 1'b0;
        for (k = 0; k < 8; k++) begin
            code_pool[k] = (CODE_BITS - 1)'($urandom());
        end

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Phase one: reset settings, the sender idles less than the receiver.
        set_idling(34, 61);

        // Directed words. Gaps are chosen against the reset windows: the
        // frame time is 20 after a sync or a 1 bit and 8 after a 0 bit.
        queue_word(FUNC_UNUSED, 8'd255, 8'd255);
        queue_word(FUNC_ACK, 8'd0, 8'd0);
        queue_word(FUNC_CLEAR, 8'd255, 8'd0);
        queue_word(FUNC_PULSE, 8'd0, 8'd0);       // far too short, ignored
        queue_word(FUNC_PULSE, 8'd13, 8'd255);    // one tick short, ignored
        queue_word(FUNC_PULSE, 8'd14, 8'd0);      // shortest accepted, sync
        queue_word(FUNC_PULSE, 8'd255, 8'd7);     // 0 bit at the low window edge
        queue_word(FUNC_PULSE, 8'd20, 8'd27);     // 0 bit at the high window edge
        queue_word(FUNC_PULSE, 8'd20, 8'd32);     // 1 bit at the low window edge
        queue_word(FUNC_PULSE, 8'd20, 8'd27);     // 1 bit at the high window edge
        queue_word(FUNC_PULSE, 8'd20, 8'd6);      // just short of zero window: abort
        queue_word(FUNC_PULSE, 8'd20, 8'd15);     // 0 bit
        queue_word(FUNC_PULSE, 8'd20, 8'd48);     // gap at timeout adds nothing: abort
        queue_word(FUNC_PULSE, 8'd20, 8'd21);     // 1 bit
        queue_word(FUNC_PULSE, 8'd20, 8'd28);     // just past the one window: abort
        queue_word(FUNC_PULSE, 8'd20, 8'd255);    // saturated gap: abort
        queue_word(FUNC_PULSE, 8'd20, 8'd47);     // just below timeout, far too late
        queue_word(FUNC_ACK, 8'd255, 8'd255);
        queue_word(FUNC_UNUSED, 8'd0, 8'd0);

        // Hold the sender off until everything so far has come back.
        wait_drained();
        queue_mixed(120);
        wait_drained();

        // Phase two: the receiver idles less than the sender.
        set_idling(61, 34);

        // Zero window reached only through the 8-bit wrap; longest timeout;
        // every pulse wide enough.
        load_settings(8'd0, 8'd0, 8'd5, 8'd100, 8'd130, 8'd255);
        queue_mixed(90);
        wait_drained();

        // Widest zero window, shortest timeout: every full-width pulse after a
        // sync is a 0 bit, so codes complete from noise alone.
        load_settings(8'd255, 8'd0, 8'd255, 8'd0, 8'd0, 8'd1);
        queue_noise(50, 80, 60);
        wait_drained();

        // Inverted zero window that matches nothing, one window at the top.
        load_settings(8'd128, 8'd255, 8'd0, 8'd255, 8'd255, 8'd128);
        queue_noise(50, 70, 30);
        wait_drained();

        // Phase three: no idling on either side, reset settings again.
        set_idling(0, 0);
        load_settings(RST_MIN_WIDTH, RST_ZERO_LOW, RST_ZERO_HIGH, RST_ONE_LOW,
                      RST_ONE_HIGH, RST_TIMEOUT);
        // Two codes learned into an empty store; after the acknowledge the
        // first one is found again without raising the mark. Clearing the
        // store keeps the mark, and the second code is then new once more.
        queue_word(FUNC_CLEAR, 8'd0, 8'd0);
        queue_frame(fill_payload(0), 1'b0);
        queue_frame(fill_payload(1), 1'b0);
        queue_word(FUNC_ACK, 8'd0, 8'd0);
        queue_frame(fill_payload(0), 1'b0);
        queue_word(FUNC_CLEAR, 8'd0, 8'd0);
        queue_frame(fill_payload(1), 1'b0);
        wait_drained();

        queue_mixed(40);
        wait_drained();

        // Let any stray result word surface before the verdict.
        repeat (SETTLE_CYCLES) @(posedge clk);

        $display("Run covered %0d words: %0d codes known, %0d learned, %0d refused (store full).",
                 words_accepted, known_codes, learned_codes_seen, refused_codes);
        $display("Settings: reset, wrapped zero window, saturating, empty windows; %0d mismatches.",
                 mismatches);
        if (mismatches == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule

[pulse_position_code_receiver_core.f]
+incdir+rtl/core
rtl/core/ppcr_pkg.sv
rtl/core/ppcr_store.sv
rtl/core/pulse_position_code_receiver_core.sv
tb/sv/testbench.sv
